### hw/rtl/gtw_pkg.sv
// gaussian tap weight generator: shared types and constants
// used by gtw_div, gtw_ctrl, gtw_dp and the top level; no dependencies
`timescale 1ns / 1ps

package gtw_pkg;

  // shared divider sizes
  localparam int DIV_W  = 72;
  localparam int DIV_QW = 22;
  localparam int DIV_CW = 5;

  // quotient bit counts per division kind
  localparam int Q_RATIO = 15;
  localparam int Q_EXP   = 22;
  localparam int Q_OFF   = 22;
  localparam int Q_WT    = 17;

  localparam int OFF_W = 22;

  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [31:0] TOTAL_MIN_Q30 = 32'd1073741;

  // reciprocals for exact floor division of 32-bit values by 5 (shift 34) and 3 (shift 33)
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RATIO,
    CMD_PHASE,
    CMD_EXP,
    CMD_X,
    CMD_D5,
    CMD_T_D5,
    CMD_MUL_XT,
    CMD_T_SH2,
    CMD_D3,
    CMD_T_D3,
    CMD_T_SH1,
    CMD_T_SH0,
    CMD_MUL_TT,
    CMD_T_SQ,
    CMD_SAVE,
    CMD_W,
    CMD_M2,
    CMD_M3,
    CMD_OFF,
    CMD_OFF_ST,
    CMD_SCAN_INIT,
    CMD_SCAN,
    CMD_WDIV,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic div_busy;
    logic div_sat;
    logic sq_last;
    logic j_second;
    logic last_tap;
    logic tiny;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/gtw_div.sv
// restoring divider, one quotient bit per cycle
// depends on gtw_pkg for widths
`timescale 1ns / 1ps

module gtw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gtw_pkg::DIV_W-1:0]  num_i,
  input  logic [gtw_pkg::DIV_W-1:0]  den_sh_i,   // divisor pre-shifted to top quotient bit
  input  logic [gtw_pkg::DIV_CW-1:0] cnt_i,
  output logic [gtw_pkg::DIV_QW-1:0] q_o,
  output logic                       busy_o
);

  logic [gtw_pkg::DIV_W-1:0]  rem_q, dsh_q;
  logic [gtw_pkg::DIV_QW-1:0] quo_q;
  logic [gtw_pkg::DIV_CW-1:0] cnt_q;
  logic                       ge;

  assign ge     = rem_q >= dsh_q;
  assign q_o    = quo_q;
  assign busy_o = cnt_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= cnt_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= den_sh_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[gtw_pkg::DIV_QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

endmodule

### hw/rtl/gtw_ctrl.sv
// sequencer for the tap weight generator: one-hot state machine issuing datapath commands
// depends on gtw_pkg for command and status types
`timescale 1ns / 1ps

module gtw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output gtw_pkg::cmd_e    cmd_o,
  input  gtw_pkg::status_t st_i
);

  typedef enum logic [28:0] {
    S_IDLE   = 29'(1) << 0,
    S_RATIO  = 29'(1) << 1,
    S_RATIO_W = 29'(1) << 2,
    S_EXP    = 29'(1) << 3,
    S_EXP_W  = 29'(1) << 4,
    S_D5     = 29'(1) << 5,
    S_D5_T   = 29'(1) << 6,
    S_M1     = 29'(1) << 7,
    S_T1     = 29'(1) << 8,
    S_M2     = 29'(1) << 9,
    S_D3     = 29'(1) << 10,
    S_D3_T   = 29'(1) << 11,
    S_M3     = 29'(1) << 12,
    S_T3     = 29'(1) << 13,
    S_M4     = 29'(1) << 14,
    S_T4     = 29'(1) << 15,
    S_SQM    = 29'(1) << 16,
    S_SQT    = 29'(1) << 17,
    S_SAVE   = 29'(1) << 18,
    S_W      = 29'(1) << 19,
    S_P2     = 29'(1) << 20,
    S_P3     = 29'(1) << 21,
    S_OFF    = 29'(1) << 22,
    S_OFF_W  = 29'(1) << 23,
    S_SCAN0  = 29'(1) << 24,
    S_SCAN   = 29'(1) << 25,
    S_WT     = 29'(1) << 26,
    S_WT_W   = 29'(1) << 27,
    S_EMIT   = 29'(1) << 28
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = gtw_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o   = gtw_pkg::CMD_LOAD;
          state_d = S_RATIO;
        end
      end
      S_RATIO: begin
        cmd_o   = gtw_pkg::CMD_RATIO;
        state_d = S_RATIO_W;
      end
      S_RATIO_W: begin
        if (!st_i.div_busy) begin
          cmd_o   = gtw_pkg::CMD_PHASE;
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        cmd_o   = gtw_pkg::CMD_EXP;
        state_d = S_EXP_W;
      end
      S_EXP_W: begin
        if (!st_i.div_busy) begin
          cmd_o   = gtw_pkg::CMD_X;
          // exponent of 32 or more gives a zero sample
          state_d = st_i.div_sat ? S_SAVE : S_D5;
        end
      end
      S_D5: begin
        cmd_o   = gtw_pkg::CMD_D5;
        state_d = S_D5_T;
      end
      S_D5_T: begin
        cmd_o   = gtw_pkg::CMD_T_D5;
        state_d = S_M1;
      end
      S_M1: begin
        cmd_o   = gtw_pkg::CMD_MUL_XT;
        state_d = S_T1;
      end
      S_T1: begin
        cmd_o   = gtw_pkg::CMD_T_SH2;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o   = gtw_pkg::CMD_MUL_XT;
        state_d = S_D3;
      end
      S_D3: begin
        cmd_o   = gtw_pkg::CMD_D3;
        state_d = S_D3_T;
      end
      S_D3_T: begin
        cmd_o   = gtw_pkg::CMD_T_D3;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o   = gtw_pkg::CMD_MUL_XT;
        state_d = S_T3;
      end
      S_T3: begin
        cmd_o   = gtw_pkg::CMD_T_SH1;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o   = gtw_pkg::CMD_MUL_XT;
        state_d = S_T4;
      end
      S_T4: begin
        cmd_o   = gtw_pkg::CMD_T_SH0;
        state_d = S_SQM;
      end
      S_SQM: begin
        cmd_o   = gtw_pkg::CMD_MUL_TT;
        state_d = S_SQT;
      end
      S_SQT: begin
        cmd_o   = gtw_pkg::CMD_T_SQ;
        state_d = st_i.sq_last ? S_SAVE : S_SQM;
      end
      S_SAVE: begin
        cmd_o   = gtw_pkg::CMD_SAVE;
        state_d = st_i.j_second ? S_W : S_EXP;
      end
      S_W: begin
        cmd_o   = gtw_pkg::CMD_W;
        state_d = S_P2;
      end
      S_P2: begin
        cmd_o   = gtw_pkg::CMD_M2;
        state_d = S_P3;
      end
      S_P3: begin
        cmd_o   = gtw_pkg::CMD_M3;
        state_d = S_OFF;
      end
      S_OFF: begin
        cmd_o   = gtw_pkg::CMD_OFF;
        state_d = S_OFF_W;
      end
      S_OFF_W: begin
        if (!st_i.div_busy) begin
          cmd_o   = gtw_pkg::CMD_OFF_ST;
          state_d = st_i.last_tap ? S_SCAN0 : S_EXP;
        end
      end
      S_SCAN0: begin
        cmd_o   = gtw_pkg::CMD_SCAN_INIT;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o   = gtw_pkg::CMD_SCAN;
        state_d = st_i.last_tap ? S_WT : S_SCAN;
      end
      S_WT: begin
        if (st_i.tiny) begin
          state_d = S_EMIT;
        end else begin
          cmd_o   = gtw_pkg::CMD_WDIV;
          state_d = S_WT_W;
        end
      end
      S_WT_W: begin
        if (!st_i.div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o   = gtw_pkg::CMD_EMIT;
          state_d = st_i.last_tap ? S_IDLE : S_WT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/gtw_dp.sv
// datapath: operand registers, shared multiplier, shared divider, tap stores, output register
// depends on gtw_pkg and gtw_div
`timescale 1ns / 1ps

module gtw_dp #(
  parameter int MAX_TAPS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gtw_pkg::cmd_e    cmd_i,
  output gtw_pkg::status_t st_o,
  input  logic [47:0]      s_tdata_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [47:0]      m_tdata_o,
  output logic             m_tuser_o,
  output logic             m_tlast_o
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int N_W   = $clog2(MAX_TAPS + 1);
  localparam int H_W   = IDX_W + 2;
  localparam int HH_W  = 2 * H_W;
  localparam int PR_W  = H_W + 31;
  localparam int TOT_W = 32 + IDX_W;
  localparam int CMP_W = TOT_W + 8;
  localparam int DW    = gtw_pkg::DIV_W;

  // input fields
  logic [11:0] sig_in, sig_fix;
  logic [13:0] src_in, dst_in, src_fix, dst_fix;
  logic [3:0]  n_in;
  logic [N_W-1:0] n_fix;

  // item registers
  logic [13:0]      src_q, dst_q;
  logic [23:0]      ss_q;
  logic [N_W-1:0]   n_q, half_q;
  logic             bad_q, p_q, tiny_q, sat_q;
  logic [IDX_W-1:0] i_q;
  logic             j_q, found_q;
  logic [2:0]       sq_q;
  logic [26:0]      x_q;
  logic [30:0]      t_q, a_q, b_q;
  logic [31:0]      w_cur_q;
  logic [PR_W-1:0]  prod1_q, prod2_q;
  logic [TOT_W-1:0] total_q;
  logic [63:0]      mul_q;
  logic [31:0]      w_mem [MAX_TAPS];
  logic [gtw_pkg::OFF_W-1:0] off_mem [MAX_TAPS];

  // output register
  logic        out_valid_q;
  logic [2:0]  o_num_q;
  logic [23:0] o_off_q;
  logic [15:0] o_wt_q;
  logic [3:0]  o_half_q;
  logic        o_bad_q, o_last_q;

  // combinational helpers
  logic [H_W-1:0]  h, ha, hb;
  logic [HH_W-1:0] hh;
  logic [31:0]     w_new, w_sel;
  logic [CMP_W-1:0] w50;
  logic            below, last_tap, out_free;
  logic [15:0]     wt_val;

  // divider and multiplier controls
  logic                       div_start, div_busy;
  logic [DW-1:0]              div_num, div_den;
  logic [gtw_pkg::DIV_CW-1:0] div_cnt;
  logic [gtw_pkg::DIV_QW-1:0] div_q;
  logic                       mul_en;
  logic [31:0]                mul_a, mul_b;

  assign sig_in  = s_tdata_i[11:0];
  assign src_in  = s_tdata_i[25:12];
  assign dst_in  = s_tdata_i[39:26];
  assign n_in    = s_tdata_i[43:40];
  assign sig_fix = (sig_in == '0) ? 12'd1 : sig_in;
  assign src_fix = (src_in == '0) ? 14'd1 : src_in;
  assign dst_fix = (dst_in == '0) ? 14'd1 : dst_in;

  always_comb begin
    if (n_in == '0) begin
      n_fix = N_W'(1);
    end else if (int'(n_in) > MAX_TAPS) begin
      n_fix = N_W'(MAX_TAPS);
    end else begin
      n_fix = N_W'(n_in);
    end
  end

  // half-pixel positions: 4*i + 2*j + phase
  assign h  = {i_q, j_q, p_q};
  assign ha = {i_q, 1'b0, p_q};
  assign hb = {i_q, 1'b1, p_q};
  assign hh = HH_W'(h) * HH_W'(h);

  assign w_new    = {1'b0, a_q} + {1'b0, b_q};
  assign w_sel    = w_mem[i_q];
  assign w50      = (CMP_W'(w_sel) << 5) + (CMP_W'(w_sel) << 4) + (CMP_W'(w_sel) << 1);
  assign below    = w50 < CMP_W'(total_q);
  assign last_tap = N_W'(i_q) == (n_q - N_W'(1));
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    if (tiny_q) begin
      wt_val = (i_q == '0) ? 16'h8000 : 16'h0000;
    end else begin
      wt_val = div_q[15:0];
    end
  end

  assign st_o.div_busy = div_busy;
  assign st_o.div_sat  = div_q[gtw_pkg::Q_EXP-1];
  assign st_o.sq_last  = sq_q == 3'd7;
  assign st_o.j_second = j_q;
  assign st_o.last_tap = last_tap;
  assign st_o.tiny     = tiny_q;
  assign st_o.out_free = out_free;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_cnt   = '0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd_i)
      gtw_pkg::CMD_RATIO: begin
        div_start = 1'b1;
        div_num   = DW'({src_q, 1'b0}) + DW'(dst_q);
        div_den   = DW'({dst_q, 1'b0}) << (gtw_pkg::Q_RATIO - 1);
        div_cnt   = gtw_pkg::DIV_CW'(gtw_pkg::Q_RATIO);
      end
      gtw_pkg::CMD_EXP: begin
        div_start = 1'b1;
        div_num   = DW'(hh) << 29;
        div_den   = DW'(ss_q) << (gtw_pkg::Q_EXP - 1);
        div_cnt   = gtw_pkg::DIV_CW'(gtw_pkg::Q_EXP);
      end
      gtw_pkg::CMD_D5: begin
        // x / 5 through the reciprocal, taken from the product next cycle
        mul_en = 1'b1;
        mul_a  = 32'(x_q);
        mul_b  = gtw_pkg::RECIP5;
      end
      gtw_pkg::CMD_D3: begin
        mul_en = 1'b1;
        mul_a  = 32'(mul_q >> 30);
        mul_b  = gtw_pkg::RECIP3;
      end
      gtw_pkg::CMD_OFF: begin
        div_start = 1'b1;
        div_cnt   = gtw_pkg::DIV_CW'(gtw_pkg::Q_OFF);
        if (w_cur_q == '0) begin
          // zero weight: plain mean of the two positions
          div_num = ((DW'(ha) + DW'(hb)) << 16) + DW'({src_q, 1'b0});
          div_den = DW'({src_q, 2'b00}) << (gtw_pkg::Q_OFF - 1);
        end else begin
          div_num = ((DW'(prod1_q) + DW'(prod2_q)) << 16) + DW'(mul_q);
          div_den = DW'({mul_q, 1'b0}) << (gtw_pkg::Q_OFF - 1);
        end
      end
      gtw_pkg::CMD_WDIV: begin
        div_start = 1'b1;
        div_num   = (DW'(w_sel) << 15) + DW'(total_q >> 1);
        div_den   = DW'(total_q) << (gtw_pkg::Q_WT - 1);
        div_cnt   = gtw_pkg::DIV_CW'(gtw_pkg::Q_WT);
      end
      gtw_pkg::CMD_MUL_XT: begin
        mul_en = 1'b1;
        mul_a  = 32'(x_q);
        mul_b  = 32'(t_q);
      end
      gtw_pkg::CMD_MUL_TT: begin
        mul_en = 1'b1;
        mul_a  = 32'(t_q);
        mul_b  = 32'(t_q);
      end
      gtw_pkg::CMD_W: begin
        mul_en = 1'b1;
        mul_a  = 32'(ha);
        mul_b  = 32'(a_q);
      end
      gtw_pkg::CMD_M2: begin
        mul_en = 1'b1;
        mul_a  = 32'(hb);
        mul_b  = 32'(b_q);
      end
      gtw_pkg::CMD_M3: begin
        mul_en = 1'b1;
        mul_a  = 32'(src_q);
        mul_b  = w_cur_q;
      end
      default: begin
      end
    endcase
  end

  gtw_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_sh_i (div_den),
    .cnt_i    (div_cnt),
    .q_o      (div_q),
    .busy_o   (div_busy)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= 1'b0;
      sq_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == gtw_pkg::CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        gtw_pkg::CMD_LOAD: begin
          i_q <= '0;
          j_q <= 1'b0;
        end
        gtw_pkg::CMD_X: begin
          sq_q <= '0;
        end
        gtw_pkg::CMD_T_SQ: begin
          sq_q <= sq_q + 3'd1;
        end
        gtw_pkg::CMD_SAVE: begin
          j_q <= !j_q;
        end
        gtw_pkg::CMD_OFF_ST: begin
          i_q <= i_q + 1'b1;
        end
        gtw_pkg::CMD_SCAN_INIT: begin
          i_q     <= '0;
          found_q <= 1'b0;
        end
        gtw_pkg::CMD_SCAN: begin
          if (!found_q && below) begin
            found_q <= 1'b1;
          end
          i_q <= last_tap ? '0 : i_q + 1'b1;
        end
        gtw_pkg::CMD_EMIT: begin
          i_q <= last_tap ? '0 : i_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= 64'(mul_a) * 64'(mul_b);
    end
    case (cmd_i)
      gtw_pkg::CMD_LOAD: begin
        src_q   <= src_fix;
        dst_q   <= dst_fix;
        n_q     <= n_fix;
        bad_q   <= (dst_in > src_in) || (dst_in == '0) || (src_in == '0);
        ss_q    <= 24'(sig_fix) * 24'(sig_fix);
        total_q <= '0;
      end
      gtw_pkg::CMD_PHASE: begin
        // even rounded ratio puts samples on half pixels
        p_q <= !div_q[0];
      end
      gtw_pkg::CMD_X: begin
        sat_q <= div_q[gtw_pkg::Q_EXP-1];
        x_q   <= {div_q[gtw_pkg::Q_EXP-2:0], 6'b0};
      end
      gtw_pkg::CMD_T_D5: begin
        t_q <= gtw_pkg::Q30_ONE - 31'(mul_q >> 34);
      end
      gtw_pkg::CMD_T_SH2: begin
        t_q <= gtw_pkg::Q30_ONE - 31'(mul_q >> 32);
      end
      gtw_pkg::CMD_T_D3: begin
        t_q <= gtw_pkg::Q30_ONE - 31'(mul_q >> 33);
      end
      gtw_pkg::CMD_T_SH1: begin
        t_q <= gtw_pkg::Q30_ONE - 31'(mul_q >> 31);
      end
      gtw_pkg::CMD_T_SH0: begin
        t_q <= gtw_pkg::Q30_ONE - 31'(mul_q >> 30);
      end
      gtw_pkg::CMD_T_SQ: begin
        t_q <= 31'(mul_q >> 30);
      end
      gtw_pkg::CMD_SAVE: begin
        if (!j_q) begin
          if (sat_q) begin
            a_q <= '0;
          end else if (i_q == '0 && !p_q) begin
            a_q <= t_q >> 1;
          end else begin
            a_q <= t_q;
          end
        end else begin
          b_q <= sat_q ? '0 : t_q;
        end
      end
      gtw_pkg::CMD_W: begin
        w_cur_q      <= w_new;
        w_mem[i_q]   <= w_new;
        total_q      <= total_q + TOT_W'(w_new);
      end
      gtw_pkg::CMD_M2: begin
        prod1_q <= mul_q[PR_W-1:0];
      end
      gtw_pkg::CMD_M3: begin
        prod2_q <= mul_q[PR_W-1:0];
      end
      gtw_pkg::CMD_OFF_ST: begin
        off_mem[i_q] <= div_q[gtw_pkg::OFF_W-1:0];
      end
      gtw_pkg::CMD_SCAN_INIT: begin
        half_q <= n_q;
        tiny_q <= total_q <= TOT_W'(gtw_pkg::TOTAL_MIN_Q30);
      end
      gtw_pkg::CMD_SCAN: begin
        if (!found_q && below) begin
          half_q <= N_W'(i_q) + N_W'(1);
        end
      end
      gtw_pkg::CMD_EMIT: begin
        o_num_q  <= 3'(i_q);
        o_off_q  <= 24'(off_mem[i_q]);
        o_wt_q   <= wt_val;
        o_half_q <= tiny_q ? 4'd1 : 4'(half_q);
        o_bad_q  <= bad_q;
        o_last_q <= last_tap;
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, o_half_q, o_wt_q, o_off_q, o_num_q};
  assign m_tuser_o  = o_bad_q;
  assign m_tlast_o  = o_last_q;

endmodule

### hw/rtl/gaussian_tap_weight_generator.sv
// Gaussian tap weight generator, one input beat in, one output beat per merged tap out.
// Each beat is worked on alone. Its time is set by the single shared one-bit-per-cycle
// divider and the shared multiplier: a setup division, then per tap the two samples
// (shorter when a sample's exponent reaches 32 and it is taken as zero) and the offset,
// then a scan over the taps, then per tap the normalized weight and the output, which
// waits while the output register is full and not taken. A new beat is taken once
// the last tap has been loaded into the output register.
// depends on gtw_pkg, gtw_ctrl, gtw_dp
`timescale 1ns / 1ps

module gaussian_tap_weight_generator #(
  parameter int MAX_TAPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sigma[11:0], source_res[25:12], dest_res[39:26], tap_count[43:40], zero pad
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tap_number[2:0], tap_offset[26:3], tap_weight[42:27], half_count[46:43], zero pad
  output logic [47:0] m_axis_tdata_o,
  // bad_input[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  gtw_pkg::cmd_e    cmd;
  gtw_pkg::status_t st;

  gtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  gtw_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

### verif/testbench.sv
// self-checking testbench for gaussian_tap_weight_generator: random and directed
// parameter beats in, per-tap results checked against an in-bench fixed point predictor
`timescale 1ns / 1ps

module testbench;
  localparam int NUM_TAPS_MAX = 8;
  localparam int RANDOM_BEATS = 132;

  typedef struct packed {
    logic [2:0]  number;
    logic [23:0] offset;
    logic [15:0] weight;
    logic [3:0]  half;
    logic        bad;
    logic        last;
  } tap_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  logic [47:0] kernel_q[$];
  tap_t        tap_q[$];
  int          total_beats;
  int          sent_beats;
  int          accepted_beats;
  int          taps_seen;
  int          err_cnt;

  gaussian_tap_weight_generator #(.MAX_TAPS(NUM_TAPS_MAX)) u_top (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // gaussian sample exp(-8192 h^2 / s^2) in q30, h in half pixels
  function automatic longint unsigned gauss_sample(longint unsigned h, longint unsigned s);
    longint unsigned e, x, t;
    e = ((h * h) << 29) / (s * s);
    if (e >= (64'd32 << 16)) return 0;
    x = e << 6;
    t = (64'd1 << 30) - x / 5;
    t = (64'd1 << 30) - ((x * t) >> 30) / 4;
    t = (64'd1 << 30) - ((x * t) >> 30) / 3;
    t = (64'd1 << 30) - ((x * t) >> 30) / 2;
    t = (64'd1 << 30) - ((x * t) >> 30);
    for (int k = 0; k < 8; k++) t = (t * t) >> 30;
    return t;
  endfunction

  task automatic predict_taps(input logic [47:0] d);
    longint unsigned sig, src, dst, n, ratio, ph, ha, hb, a, b, dv, total, wt;
    longint unsigned w[NUM_TAPS_MAX];
    longint unsigned off[NUM_TAPS_MAX];
    logic bad, tiny;
    int half;
    tap_t t;
    sig = 64'(d[11:0]);
    src = 64'(d[25:12]);
    dst = 64'(d[39:26]);
    n = 64'(d[43:40]);
    bad = (dst > src) || (dst == 0) || (src == 0);
    if (sig == 0) sig = 1;
    if (src == 0) src = 1;
    if (dst == 0) dst = 1;
    if (n == 0) n = 1;
    if (n > NUM_TAPS_MAX) n = NUM_TAPS_MAX;
    ratio = (2 * src + dst) / (2 * dst);
    ph = ratio[0] ? 0 : 1;
    total = 0;
    for (int i = 0; i < n; i++) begin
      ha = 4 * i + ph;
      hb = ha + 2;
      a = gauss_sample(ha, sig);
      b = gauss_sample(hb, sig);
      if (i == 0 && ph == 0) a = a >> 1;
      w[i] = a + b;
      if (w[i] == 0) begin
        dv = 4 * src;
        off[i] = (((ha + hb) << 16) + dv / 2) / dv;
      end else begin
        dv = 2 * src * w[i];
        off[i] = (((ha * a + hb * b) << 16) + dv / 2) / dv;
      end
      total += w[i];
    end
    tiny = (total <= 64'd1073741);
    half = int'(n);
    if (tiny) half = 1;
    else
      for (int i = int'(n); i > 0; i--)
        if (50 * w[i-1] < total) half = i;
    for (int i = 0; i < n; i++) begin
      if (tiny) wt = (i == 0) ? 32768 : 0;
      else wt = ((w[i] << 15) + total / 2) / total;
      t.number = 3'(i);
      t.offset = off[i][23:0];
      t.weight = wt[15:0];
      t.half = 4'(half);
      t.bad = bad;
      t.last = (i + 1 == n);
      tap_q.push_back(t);
    end
  endtask

  function automatic logic [47:0] pack_kernel(int sig, int src, int dst, int n);
    return {4'b0, n[3:0], dst[13:0], src[13:0], sig[11:0]};
  endfunction

  // idle percentage per side: sender idles less first, then receiver, then none
  function automatic int idle_pct(bit recv);
    int ph;
    ph = (sent_beats * 3) / (total_beats + 1);
    if (ph == 0) return recv ? 45 : 20;
    if (ph == 1) return recv ? 20 : 45;
    return 0;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_taps(s_axis_tdata_i);
        accepted_beats++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (kernel_q.size() > 0 && $urandom_range(99, 0) >= idle_pct(1'b0)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= kernel_q.pop_front();
          sent_beats++;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tap_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[2:0], m_axis_tdata_o[26:3], m_axis_tdata_o[42:27],
               m_axis_tdata_o[46:43], m_axis_tuser_o, m_axis_tlast_o};
        taps_seen++;
        if (tap_q.size() == 0) begin
          $display("%0t: unexpected tap beat %h", $time, got);
          err_cnt++;
        end else begin
          want = tap_q.pop_front();
          if (got.number !== want.number || got.offset !== want.offset ||
              got.weight !== want.weight || got.half !== want.half ||
              got.bad !== want.bad || got.last !== want.last) begin
            $display("%0t: tap mismatch expected num=%0d off=%h wt=%h half=%0d bad=%b last=%b",
                     $time, want.number, want.offset, want.weight, want.half, want.bad,
                     want.last);
            $display("%0t:              actual   num=%0d off=%h wt=%h half=%0d bad=%b last=%b",
                     $time, got.number, got.offset, got.weight, got.half, got.bad, got.last);
            err_cnt++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= idle_pct(1'b1));
    end
  end

  initial begin
    int sig, src, dst, n;
    sent_beats = 0;
    accepted_beats = 0;
    taps_seen = 0;
    err_cnt = 0;
    // corners: zero/max fields, odd and even ratio, tiny total, bad resolutions
    kernel_q.push_back(pack_kernel(0, 1, 1, 0));
    kernel_q.push_back(pack_kernel(4095, 8192, 1, 8));
    kernel_q.push_back(pack_kernel(4095, 16383, 16383, 15));
    kernel_q.push_back(pack_kernel(1, 100, 50, 8));
    kernel_q.push_back(pack_kernel(1, 100, 100, 4));
    kernel_q.push_back(pack_kernel(512, 0, 0, 3));
    kernel_q.push_back(pack_kernel(512, 0, 10, 3));
    kernel_q.push_back(pack_kernel(512, 10, 0, 3));
    kernel_q.push_back(pack_kernel(768, 100, 200, 5));
    kernel_q.push_back(pack_kernel(256, 1920, 960, 8));
    kernel_q.push_back(pack_kernel(256, 1920, 640, 8));
    kernel_q.push_back(pack_kernel(128, 1024, 1024, 9));
    kernel_q.push_back(pack_kernel(64, 1024, 512, 8));
    kernel_q.push_back(pack_kernel(2048, 4096, 1365, 8));
    kernel_q.push_back(pack_kernel(3000, 8191, 8191, 2));
    kernel_q.push_back(pack_kernel(2730, 5461, 2730, 1));
    kernel_q.push_back(pack_kernel(300, 12000, 11999, 7));
    kernel_q.push_back(pack_kernel(40, 3000, 1000, 6));
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      sig = $urandom_range(4095, 0);
      if ($urandom_range(9, 0) == 0) begin
        src = $urandom_range(16383, 0);
        dst = $urandom_range(16383, 0);
        n = $urandom_range(15, 0);
      end else begin
        src = $urandom_range(8192, 1);
        dst = ($urandom_range(1, 0) == 0) ? $urandom_range(src, 1) :
              src / $urandom_range(6, 1);
        if (dst == 0) dst = 1;
        n = $urandom_range(8, 1);
      end
      kernel_q.push_back(pack_kernel(sig, src, dst, n));
    end
    total_beats = kernel_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (kernel_q.size() == 0 && accepted_beats == total_beats && tap_q.size() == 0);
    repeat (3000) @(posedge clk_i);
    if (tap_q.size() != 0) begin
      $display("%0t: %0d expected taps never arrived", $time, tap_q.size());
      err_cnt++;
    end
    $display("covered %0d kernel beats and %0d tap beats, %0d mismatches",
             accepted_beats, taps_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
